@@ src/frlm_pkg.sv @@
// Shared codes and types for the fair recursive reader/writer lock manager.
// No dependencies; imported by frlm_ctrl, frlm_dp and the top level.
`default_nettype none

package frlm_pkg;

    typedef logic [2:0] t_mode;
    typedef logic [3:0] t_id;
    typedef logic [3:0] t_event;
    typedef logic [4:0] t_holders;

    localparam t_mode MODE_SHARED   = 3'd0;
    localparam t_mode MODE_EXCL     = 3'd1;
    localparam t_mode MODE_RELEASE  = 3'd2;
    localparam t_mode MODE_TRANSFER = 3'd3;
    localparam t_mode MODE_RESUME   = 3'd4;

    localparam t_event EV_GRANTED     = 4'd0;
    localparam t_event EV_RECURSIVE   = 4'd1;
    localparam t_event EV_QUEUED      = 4'd2;
    localparam t_event EV_GRANT_Q     = 4'd3;
    localparam t_event EV_PARTIAL     = 4'd4;
    localparam t_event EV_RELEASED    = 4'd5;
    localparam t_event EV_TRANSFERRED = 4'd6;
    localparam t_event EV_NOT_HOLDER  = 4'd7;
    localparam t_event EV_RESUMED     = 4'd8;
    localparam t_event EV_QUEUE_FULL  = 4'd9;

    localparam t_holders HOLDERS_MAX = 5'd31;
    localparam logic [3:0] MAX_DRAIN = 4'd8;

    typedef struct packed {
        logic load;
        logic exec;
        logic drain;
    } t_cmd;

    typedef struct packed {
        logic drain_go;
    } t_sts;

endpackage

`default_nettype wire

@@ src/frlm_ctrl.sv @@
// Controller state machine: accept, execute, drain the wait queue.
// Depends on frlm_pkg (t_cmd, t_sts).
`default_nettype none

module frlm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    output frlm_pkg::t_cmd     o_cmd,
    input  wire frlm_pkg::t_sts i_sts
);
    import frlm_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        o_cmd.drain = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.drain_go ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN: begin
                o_cmd.drain = 1'b1;
                n_state     = i_sts.drain_go ? ST_DRAIN : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ src/frlm_dp.sv @@
// Datapath: hold records, holder count, wait queue memory, result register.
// Depends on frlm_pkg (codes, t_cmd, t_sts).
`default_nettype none

module frlm_dp #(
    parameter int REQUESTERS  = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int DEPTH_BITS  = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire frlm_pkg::t_cmd    i_cmd,
    output frlm_pkg::t_sts         o_sts,
    input  wire frlm_pkg::t_mode   i_mode,
    input  wire frlm_pkg::t_id     i_requester,
    output logic                   o_valid,
    output frlm_pkg::t_id          o_who,
    output frlm_pkg::t_event       o_event_res,
    output logic                   o_exclusive_now,
    output frlm_pkg::t_holders     o_holders_now,
    output logic                   o_last
);
    import frlm_pkg::*;

    localparam int NUM_IDS = (REQUESTERS < 16) ? REQUESTERS : 16;
    localparam int ID_BITS = $clog2(NUM_IDS);
    localparam int QA_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [8:0]           REQ_LIM   = 9'(REQUESTERS);
    localparam logic [QA_BITS:0]     Q_LAST    = (QA_BITS + 1)'(QUEUE_DEPTH - 1);
    localparam logic [QA_BITS:0]     Q_SIZE    = (QA_BITS + 1)'(QUEUE_DEPTH);
    localparam logic [QC_BITS-1:0]   Q_FULL    = QC_BITS'(QUEUE_DEPTH);
    localparam logic [QC_BITS-1:0]   CNT_ONE   = QC_BITS'(1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

    function automatic logic [QA_BITS-1:0] f_next(input logic [QA_BITS-1:0] a);
        logic [QA_BITS:0] s;
        s = {1'b0, a} + (QA_BITS + 1)'(1);
        if (s > Q_LAST) begin
            s = '0;
        end
        return s[QA_BITS-1:0];
    endfunction

    // request beat
    t_mode r_mode;
    t_id   r_id;

    // lock state
    logic                  r_hold_valid [NUM_IDS];
    logic [DEPTH_BITS-1:0] r_hold_depth [NUM_IDS];
    t_holders              r_total;
    t_holders              n_total;
    logic                  r_excl;
    logic                  n_excl;

    // wait queue
    logic [4:0]         r_queue [QUEUE_DEPTH];
    logic [4:0]         r_head_q;
    logic [4:0]         r_next_q;
    logic [QA_BITS-1:0] r_head;
    logic [QA_BITS-1:0] n_head;
    logic [QA_BITS-1:0] rd_next;
    logic [QC_BITS-1:0] r_count;
    logic [QC_BITS-1:0] n_count;
    logic [QA_BITS:0]   tail_sum;
    logic [QA_BITS:0]   tail_wrap;
    logic [QA_BITS-1:0] tail;
    logic               q_we;
    logic [3:0]         r_drained;
    logic [3:0]         n_drained;

    // result register
    logic   r_out_valid;
    logic   n_out_valid;
    t_id    r_out_who;
    t_id    n_out_who;
    t_event r_out_ev;
    t_event n_out_ev;
    logic   r_out_last;
    logic   n_drain_go;

    // hold record write port
    logic                  hv_we;
    logic                  hv_val;
    logic [ID_BITS-1:0]    hv_idx;
    logic                  hd_we;
    logic [DEPTH_BITS-1:0] hd_val;

    logic [ID_BITS-1:0]    id_idx;
    logic [ID_BITS-1:0]    q_idx;
    logic                  op_ok;
    logic                  is_ex;
    logic                  cur_hv;
    logic [DEPTH_BITS-1:0] cur_hd;
    t_holders              total_inc;
    t_holders              total_dec;

    assign id_idx    = r_id[ID_BITS-1:0];
    assign q_idx     = r_head_q[ID_BITS-1:0];
    assign hv_idx    = i_cmd.drain ? q_idx : id_idx;
    assign cur_hv    = r_hold_valid[hv_idx];
    assign cur_hd    = r_hold_depth[id_idx];
    assign op_ok     = (r_mode <= MODE_RESUME) && ({5'd0, r_id} < REQ_LIM);
    assign is_ex     = (r_mode == MODE_EXCL);
    assign total_inc = (r_total == HOLDERS_MAX) ? r_total : r_total + 5'd1;
    assign total_dec = (r_total != 5'd0) ? r_total - 5'd1 : r_total;

    assign tail_sum  = {1'b0, r_head} + (QA_BITS + 1)'(r_count);
    assign tail_wrap = (tail_sum > Q_LAST) ? tail_sum - Q_SIZE : tail_sum;
    assign tail      = tail_wrap[QA_BITS-1:0];
    assign rd_next   = f_next(n_head);

    always_comb begin
        n_total     = r_total;
        n_excl      = r_excl;
        n_head      = r_head;
        n_count     = r_count;
        n_drained   = r_drained;
        hv_we       = 1'b0;
        hv_val      = 1'b0;
        hd_we       = 1'b0;
        hd_val      = cur_hd;
        q_we        = 1'b0;
        n_out_valid = 1'b0;
        n_out_who   = r_id;
        n_out_ev    = EV_GRANTED;
        n_drain_go  = 1'b0;

        if (i_cmd.load) begin
            n_drained = '0;
        end

        if (i_cmd.exec && op_ok) begin
            n_out_valid = 1'b1;
            unique case (r_mode)
                MODE_SHARED, MODE_EXCL: begin
                    if (r_total == 5'd0 ||
                        (!cur_hv && r_count == '0 && !is_ex && !r_excl)) begin
                        if (!cur_hv) begin
                            hv_we  = 1'b1;
                            hv_val = 1'b1;
                            hd_we  = 1'b1;
                            hd_val = DEPTH_ONE;
                        end
                        n_excl   = is_ex;
                        n_total  = total_inc;
                        n_out_ev = EV_GRANTED;
                    end else if (cur_hv) begin
                        if (cur_hd != '1) begin
                            hd_we  = 1'b1;
                            hd_val = cur_hd + DEPTH_ONE;
                        end
                        n_out_ev = EV_RECURSIVE;
                    end else if (r_count >= Q_FULL) begin
                        n_out_ev = EV_QUEUE_FULL;
                    end else begin
                        q_we     = 1'b1;
                        n_count  = r_count + CNT_ONE;
                        n_out_ev = EV_QUEUED;
                    end
                end
                MODE_RELEASE: begin
                    if (!cur_hv) begin
                        n_out_ev = EV_NOT_HOLDER;
                    end else if (cur_hd > DEPTH_ONE) begin
                        hd_we    = 1'b1;
                        hd_val   = cur_hd - DEPTH_ONE;
                        n_out_ev = EV_PARTIAL;
                    end else begin
                        hv_we      = 1'b1;
                        hd_we      = 1'b1;
                        hd_val     = '0;
                        n_excl     = 1'b0;
                        n_total    = total_dec;
                        n_out_ev   = EV_RELEASED;
                        n_drain_go = (r_count != '0) &&
                                     ((total_dec == 5'd0) || !r_head_q[4]);
                    end
                end
                MODE_TRANSFER: begin
                    if (cur_hv) begin
                        hv_we    = 1'b1;
                        hd_we    = 1'b1;
                        hd_val   = '0;
                        n_out_ev = EV_TRANSFERRED;
                    end else begin
                        n_out_ev = EV_NOT_HOLDER;
                    end
                end
                default: begin
                    if (!cur_hv) begin
                        hv_we  = 1'b1;
                        hv_val = 1'b1;
                        hd_we  = 1'b1;
                        hd_val = DEPTH_ONE;
                    end
                    n_out_ev = EV_RESUMED;
                end
            endcase
        end

        if (i_cmd.drain) begin
            if (!cur_hv) begin
                hv_we  = 1'b1;
                hv_val = 1'b1;
                hd_we  = 1'b1;
                hd_val = DEPTH_ONE;
            end
            n_excl      = r_head_q[4];
            n_total     = total_inc;
            n_head      = f_next(r_head);
            n_count     = r_count - CNT_ONE;
            n_drained   = r_drained + 4'd1;
            n_out_valid = 1'b1;
            n_out_who   = r_head_q[3:0];
            n_out_ev    = EV_GRANT_Q;
            // holders are nonzero after a grant: only shared-after-shared fits
            n_drain_go  = (r_count != CNT_ONE) && (n_drained != MAX_DRAIN) &&
                          !r_head_q[4] && !r_next_q[4];
        end
    end

    assign o_sts.drain_go = n_drain_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_IDS; i++) begin
                r_hold_valid[i] <= 1'b0;
            end
            r_total     <= '0;
            r_excl      <= 1'b0;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (hv_we) begin
                r_hold_valid[hv_idx] <= hv_val;
            end
            r_total     <= n_total;
            r_excl      <= n_excl;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_id   <= i_requester;
        end
        if (hd_we) begin
            r_hold_depth[hv_idx] <= hd_val;
        end
        r_drained  <= n_drained;
        r_out_who  <= n_out_who;
        r_out_ev   <= n_out_ev;
        r_out_last <= !n_drain_go;
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue[tail] <= {is_ex, r_id};
        end
        r_head_q <= r_queue[n_head];
        r_next_q <= r_queue[rd_next];
    end

    assign o_valid         = r_out_valid;
    assign o_who           = r_out_who;
    assign o_event_res     = r_out_ev;
    assign o_exclusive_now = r_excl;
    assign o_holders_now   = r_total;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire

@@ src/fair_recursive_rw_lock_manager.sv @@
// Top level of the fair recursive reader/writer lock manager.
// Depends on frlm_pkg, frlm_ctrl, frlm_dp.
//
//   channel   handshake           payload
//   request   start / busy        i_mode, i_requester
//   result    o_valid (strobe)    o_who, o_event_res, o_exclusive_now,
//                                 o_holders_now, o_last
//
// A request is accepted in ST_IDLE, then executed in ST_EXEC.
// A final release then grants queued requests from ST_DRAIN (at most 8);
// the queue memory's head and next-entry read ports supply each grant.
// Each result is strobed the cycle after the cycle that produced it.
// Synchronous reset clears hold records, holder count and queue pointers.
// Results are never stalled; o_last marks the final beat of a request.
`default_nettype none

module fair_recursive_rw_lock_manager #(
    parameter int REQUESTERS  = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int DEPTH_BITS  = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire frlm_pkg::t_mode     i_mode,
    input  wire frlm_pkg::t_id       i_requester,
    output logic                     o_valid,
    output frlm_pkg::t_id            o_who,
    output frlm_pkg::t_event         o_event_res,
    output logic                     o_exclusive_now,
    output frlm_pkg::t_holders       o_holders_now,
    output logic                     o_last
);
    import frlm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    frlm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    frlm_dp #(
        .REQUESTERS  (REQUESTERS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_mode          (i_mode),
        .i_requester     (i_requester),
        .o_valid         (o_valid),
        .o_who           (o_who),
        .o_event_res     (o_event_res),
        .o_exclusive_now (o_exclusive_now),
        .o_holders_now   (o_holders_now),
        .o_last          (o_last)
    );

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_cmd.exec || w_cmd.drain))
        else $error("result strobe without an execute or drain cycle");

    a_drain_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.drain |=> (o_valid && o_event_res == EV_GRANT_Q))
        else $error("drain cycle did not produce a queued grant");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("non-final beat while controller idle");

    a_excl_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_exclusive_now) |-> (o_holders_now != 5'd0))
        else $error("exclusive hold with zero holders");

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Testbench for fair_recursive_rw_lock_manager: directed and random lock requests,
// checked against a cycle-free lock predictor kept in a small scoreboard class.
// Depends on frlm_pkg and the RTL under src/.
`timescale 1ns / 100ps

module tb;
    import frlm_pkg::*;

    localparam int NREQ = 16;
    localparam int QDEPTH = 8;
    localparam int RUN_LIMIT = 400000;
    localparam int TAIL_CYCLES = 24;
    localparam t_mode MODE_SPARE_FIRST = 3'd5;
    localparam t_mode MODE_SPARE_LAST = 3'd7;

    typedef struct packed {
        t_id      who;
        t_event   ev;
        logic     excl;
        t_holders holders;
        logic     last;
    } t_lock_event;

    class lock_tracker;
        bit          held[NREQ];
        logic [7:0]  depth[NREQ];
        t_holders    holders;
        logic        excl;
        logic [4:0]  waitq[QDEPTH];
        logic [2:0]  head;
        logic [3:0]  waiting;
        t_lock_event due[$];
        int          mismatches;
        int          requests;
        int          events_seen;
        int          peak_holders;
        int          peak_depth;
        int          fulls;

        function new();
            for (int i = 0; i < NREQ; i++) begin
                held[i] = 1'b0;
                depth[i] = '0;
            end
            holders = '0;
            excl = 1'b0;
            head = '0;
            waiting = '0;
        endfunction

        task report(string msg);
            $display("tb: mismatch: %s", msg);
            mismatches++;
        endtask

        function void push(t_id who, t_event ev);
            t_lock_event e;
            e = '{who, ev, excl, holders, 1'b0};
            due.push_back(e);
        endfunction

        function void take_lock(t_id id, logic ex);
            if (!held[id]) begin
                held[id] = 1'b1;
                depth[id] = 8'd1;
            end
            excl = ex;
            if (holders < HOLDERS_MAX) holders++;
        endfunction

        function bit head_fits();
            if (holders == 0) return 1'b1;
            if (excl) return 1'b0;
            return !waitq[head][4];
        endfunction

        function t_id pick_holder();
            int base;
            base = $urandom_range(0, NREQ - 1);
            for (int i = 0; i < NREQ; i++)
                if (held[(base + i) % NREQ]) return t_id'((base + i) % NREQ);
            return t_id'(base);
        endfunction

        function void note_request(t_mode m, t_id r);
            logic       ex;
            logic [2:0] slot;
            logic [4:0] e;
            int         drained;
            if (m > MODE_RESUME) return;
            requests++;
            if (m == MODE_SHARED || m == MODE_EXCL) begin
                ex = (m == MODE_EXCL);
                if (holders == 0) begin
                    take_lock(r, ex);
                    push(r, EV_GRANTED);
                end else if (held[r]) begin
                    if (depth[r] != '1) depth[r]++;
                    push(r, EV_RECURSIVE);
                end else if (waiting == 0 && (ex ? holders == 0 : !excl)) begin
                    take_lock(r, ex);
                    push(r, EV_GRANTED);
                end else if (waiting >= QDEPTH) begin
                    fulls++;
                    push(r, EV_QUEUE_FULL);
                end else begin
                    slot = head + waiting[2:0];
                    waitq[slot] = {ex, r};
                    waiting++;
                    push(r, EV_QUEUED);
                end
            end else if (m == MODE_RELEASE) begin
                if (!held[r]) begin
                    push(r, EV_NOT_HOLDER);
                end else if (depth[r] > 1) begin
                    depth[r]--;
                    push(r, EV_PARTIAL);
                end else begin
                    held[r] = 1'b0;
                    depth[r] = '0;
                    excl = 1'b0;
                    if (holders > 0) holders--;
                    push(r, EV_RELEASED);
                    drained = 0;
                    while (drained < MAX_DRAIN && waiting != 0 && head_fits()) begin
                        e = waitq[head];
                        head++;
                        waiting--;
                        take_lock(e[3:0], e[4]);
                        push(e[3:0], EV_GRANT_Q);
                        drained++;
                    end
                end
            end else if (m == MODE_TRANSFER) begin
                if (held[r]) begin
                    held[r] = 1'b0;
                    depth[r] = '0;
                    push(r, EV_TRANSFERRED);
                end else begin
                    push(r, EV_NOT_HOLDER);
                end
            end else begin
                if (!held[r]) begin
                    held[r] = 1'b1;
                    depth[r] = 8'd1;
                end
                push(r, EV_RESUMED);
            end
            due[due.size() - 1].last = 1'b1;
            if (holders > peak_holders) peak_holders = holders;
            if (depth[r] > peak_depth) peak_depth = depth[r];
        endfunction

        task check_event(t_id who, t_event ev, logic ex, t_holders hc, logic lst);
            t_lock_event got;
            t_lock_event want;
            got = '{who, ev, ex, hc, lst};
            events_seen++;
            if (due.size() == 0) begin
                report($sformatf("unexpected event who=%0d ev=%0d excl=%0d holders=%0d last=%0d",
                                 who, ev, ex, hc, lst));
            end else begin
                want = due.pop_front();
                if (got !== want)
                    report($sformatf("who %0d/%0d ev %0d/%0d excl %0d/%0d hold %0d/%0d last %0d/%0d",
                                     got.who, want.who, got.ev, want.ev, got.excl, want.excl,
                                     got.holders, want.holders, got.last, want.last));
            end
        endtask
    endclass

    logic     i_clk;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_mode    i_mode = MODE_SHARED;
    t_id      i_requester = '0;
    logic     o_valid;
    t_id      o_who;
    t_event   o_event_res;
    logic     o_exclusive_now;
    t_holders o_holders_now;
    logic     o_last;

    lock_tracker tracker;
    int          cycles = 0;
    int          burst_left = 4;

    fair_recursive_rw_lock_manager uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_requester    (i_requester),
        .o_valid        (o_valid),
        .o_who          (o_who),
        .o_event_res    (o_event_res),
        .o_exclusive_now(o_exclusive_now),
        .o_holders_now  (o_holders_now),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            tracker.check_event(o_who, o_event_res, o_exclusive_now, o_holders_now, o_last);
    end

    // start stays high across back-to-back beats
    task automatic send_req(t_mode m, t_id r);
        start <= 1'b1;
        i_mode <= m;
        i_requester <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_request(m, r);
    endtask

    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
        end
    endtask

    task automatic send(t_mode m, t_id r);
        send_req(m, r);
        pace();
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.due.size() != 0) @(posedge i_clk);
    endtask

    // drop, re-add and release holds until the lock is free and nobody waits, or 80 rounds pass
    task automatic free_lock();
        t_id id;
        int  guard;
        guard = 0;
        while ((tracker.holders != 0 || tracker.waiting != 0) && guard < 80) begin
            id = t_id'($urandom_range(0, NREQ - 1));
            send(MODE_TRANSFER, id);
            send(MODE_RESUME, id);
            send(MODE_RELEASE, id);
            guard++;
        end
    endtask

    task automatic random_item(output t_mode m);
        int  pick;
        t_id id;
        pick = $urandom_range(0, 99);
        id = t_id'($urandom_range(0, NREQ - 1));
        if (pick < 38) begin
            m = (pick < 22) ? MODE_SHARED : MODE_EXCL;
            if ($urandom_range(0, 9) < 3) id = tracker.pick_holder();
        end else if (pick < 62) begin
            m = MODE_RELEASE;
            if ($urandom_range(0, 9) < 8) id = tracker.pick_holder();
        end else if (pick < 72) begin
            m = MODE_TRANSFER;
            if ($urandom_range(0, 1) == 1) id = tracker.pick_holder();
        end else if (pick < 84) begin
            m = MODE_RESUME;
        end else if (pick < 90) begin
            m = t_mode'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        end else begin
            m = t_mode'($urandom_range(0, 7));
        end
        send(m, id);
    endtask

    initial begin
        t_mode m;
        t_id   id;
        int    n;
        tracker = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full queue behind an exclusive holder, then one release drains it all
        send(MODE_EXCL, t_id'(0));
        for (int k = 1; k <= 8; k++) send(MODE_SHARED, t_id'(k));
        send(MODE_SHARED, t_id'(9));
        send(MODE_RELEASE, t_id'(0));
        send(MODE_SHARED, t_id'(1));
        send(MODE_RELEASE, t_id'(1));
        send(MODE_RELEASE, t_id'(1));
        send(MODE_RELEASE, t_id'(15));
        send(MODE_EXCL, t_id'(15));
        send(MODE_SHARED, t_id'(9));
        send(MODE_TRANSFER, t_id'(2));
        send(MODE_TRANSFER, t_id'(2));
        send(MODE_RESUME, t_id'(2));
        send(MODE_RESUME, t_id'(2));
        for (int k = MODE_SPARE_FIRST; k <= MODE_SPARE_LAST; k++)
            send(t_mode'(k), t_id'(3 * k));
        free_lock();
        send(MODE_RESUME, t_id'(7));
        send(MODE_RELEASE, t_id'(7));
        wait_drained();

        n = 0;
        while (n < 24) begin
            random_item(m);
            if (m <= MODE_RESUME) n++;
        end
        wait_drained();

        // recursion depth saturation
        id = t_id'($urandom_range(0, NREQ - 1));
        send(MODE_RESUME, id);
        repeat (256) send($urandom_range(0, 1) ? MODE_EXCL : MODE_SHARED, id);
        repeat (3) send(MODE_RELEASE, id);
        send(MODE_TRANSFER, id);
        wait_drained();

        // holder count saturation through grants whose records are dropped
        free_lock();
        for (int k = 0; k < 32; k++) begin
            send(MODE_SHARED, t_id'(k));
            send(MODE_TRANSFER, t_id'(k));
        end
        send(MODE_EXCL, t_id'($urandom_range(0, NREQ - 1)));
        send_req(MODE_RESUME, t_id'($urandom_range(0, NREQ - 1)));

        start <= 1'b0;
        while (tracker.due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.due.size() != 0)
            tracker.report($sformatf("%0d events never arrived", tracker.due.size()));
        $display("tb: %0d requests sent, %0d lock events checked, %0d queue-full rejects",
                 tracker.requests, tracker.events_seen, tracker.fulls);
        $display("tb: peak holder count %0d, deepest recursion %0d",
                 tracker.peak_holders, tracker.peak_depth);
        if (tracker.mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
